/* hdl/pba_pkg.sv */
// Shared constants, types and helper functions for the padded block average core.
package pba_pkg;

  localparam int MAX_BLOCK   = 16;
  localparam int SAMPLE_BITS = 12;

  localparam int SIZE_W  = 5;
  localparam int SHIFT_W = 4;
  localparam int DEPTH_W = 4;
  localparam int POS_W   = $clog2(MAX_BLOCK);
  localparam int CMP_W   = $clog2(MAX_BLOCK + 1) + SIZE_W;
  localparam int WGT_W   = SIZE_W;
  localparam int PROD_W  = 2 * WGT_W;
  localparam int SUM_W   = 20;
  localparam int ACC_W   = PROD_W + SAMPLE_BITS + 1;
  localparam int SH_W    = SHIFT_W + 1;
  localparam int SQ_W    = 2 * SIZE_W;
  localparam int COUNT_W = 9;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_AMOUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_DEPTH    = 2'd2;

  localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST = 5'd8;
  localparam logic [SHIFT_W-1:0] SHIFT_RST      = 4'd6;
  localparam logic [DEPTH_W-1:0] DEPTH_BASE     = 4'd8;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic take;
    logic adv;
    logic emit;
    logic busy;
  } pba_cmd_t;

  typedef struct packed {
    logic last;
  } pba_stat_t;

  function automatic logic [CMP_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(v);
    if (ext == '0) begin
      return CMP_W'(1);
    end else if (ext > CMP_W'(MAX_BLOCK)) begin
      return CMP_W'(MAX_BLOCK);
    end
    return ext;
  endfunction

  function automatic logic [WGT_W-1:0] pad_weight(input logic [SIZE_W-1:0] bs,
                                                 input logic [CMP_W-1:0] v);
    logic [CMP_W-1:0] bs_ext;
    bs_ext = CMP_W'(bs);
    if (bs_ext >= v) begin
      return WGT_W'(bs_ext - v + CMP_W'(1));
    end
    return WGT_W'(1);
  endfunction

endpackage

/* hdl/pba_ctrl.sv */
// Controller for the padded block average core: stage occupancy and output handshake.
module pba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_stall_i,
  input  pba_pkg::pba_stat_t  stat_i,
  output pba_pkg::pba_cmd_t   cmd_o,
  output logic                in_stall_o,
  output logic                out_valid_o
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_BUSY  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic busy, adv, take, emit, stall;

  always_comb begin
    busy  = (state_q == ST_BUSY);
    adv   = busy && (!stat_i.last || !out_valid_q || !out_stall_i);
    stall = busy && !adv;
    take  = in_valid_i && !stall;
    emit  = adv && stat_i.last;

    case (state_q)
      ST_EMPTY: begin
        state_d = take ? ST_BUSY : ST_EMPTY;
      end
      ST_BUSY: begin
        state_d = (take || !adv) ? ST_BUSY : ST_EMPTY;
      end
      default: begin
        state_d = ST_EMPTY;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EMPTY;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o.take  = take;
  assign cmd_o.adv   = adv;
  assign cmd_o.emit  = emit;
  assign cmd_o.busy  = busy;
  assign in_stall_o  = stall;
  assign out_valid_o = out_valid_q;

endmodule

/* hdl/pba_dp.sv */
// Datapath for the padded block average core: weights, accumulator and result registers.
module pba_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pba_pkg::pba_cmd_t                   cmd_i,
  input  logic                                cfg_we_i,
  input  logic [pba_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pba_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [pba_pkg::SAMPLE_BITS-1:0]     sample_i,
  input  logic [pba_pkg::SIZE_W-1:0]          valid_width_i,
  input  logic [pba_pkg::SIZE_W-1:0]          valid_height_i,
  output pba_pkg::pba_stat_t                  stat_o,
  output logic [pba_pkg::SUM_W-1:0]           block_mean_o,
  output logic [pba_pkg::COUNT_W-1:0]         sample_count_o
);

  logic [pba_pkg::SIZE_W-1:0]      block_size_q;
  logic [pba_pkg::SHIFT_W-1:0]     shift_q;
  logic [pba_pkg::DEPTH_W-1:0]     depth_q;

  logic [pba_pkg::POS_W-1:0]       col_q, col_d;
  logic [pba_pkg::POS_W-1:0]       row_q, row_d;
  logic [pba_pkg::SUM_W-1:0]       sum_q, sum_d;

  logic [pba_pkg::SAMPLE_BITS-1:0] s1_sample_q;
  logic [pba_pkg::PROD_W-1:0]      s1_w_q, s1_w_d;
  logic                            s1_last_q, s1_last_d;

  logic [pba_pkg::SUM_W-1:0]       mean_q, mean_d;
  logic [pba_pkg::COUNT_W-1:0]     count_q, count_d;

  logic [pba_pkg::CMP_W-1:0]       vw, vh, col_inc, row_inc;
  logic                            row_end, last_row;
  logic [pba_pkg::WGT_W-1:0]       wc, wr;
  logic [pba_pkg::ACC_W-1:0]       acc;
  logic [pba_pkg::SUM_W-1:0]       sum_sat;
  logic [pba_pkg::SH_W-1:0]        sh;
  logic [pba_pkg::SQ_W-1:0]        sq;

  always_comb begin
    vw       = pba_pkg::clamp_size(valid_width_i);
    vh       = pba_pkg::clamp_size(valid_height_i);
    col_inc  = pba_pkg::CMP_W'(col_q) + pba_pkg::CMP_W'(1);
    row_inc  = pba_pkg::CMP_W'(row_q) + pba_pkg::CMP_W'(1);
    row_end  = (col_inc >= vw);
    last_row = (row_inc >= vh);
    wc = row_end ? pba_pkg::pad_weight(block_size_q, vw) : pba_pkg::WGT_W'(1);
    wr = last_row ? pba_pkg::pad_weight(block_size_q, vh) : pba_pkg::WGT_W'(1);
    s1_w_d    = pba_pkg::PROD_W'(wc) * pba_pkg::PROD_W'(wr);
    s1_last_d = row_end && last_row;

    col_d = col_q;
    row_d = row_q;
    if (cmd_i.take) begin
      if (row_end) begin
        col_d = '0;
        row_d = last_row ? '0 : pba_pkg::POS_W'(row_inc);
      end else begin
        col_d = pba_pkg::POS_W'(col_inc);
      end
    end

    acc = pba_pkg::ACC_W'(sum_q)
        + pba_pkg::ACC_W'(s1_w_q) * pba_pkg::ACC_W'(s1_sample_q);
    sum_sat = (acc > pba_pkg::ACC_W'(pba_pkg::SUM_MAX)) ? pba_pkg::SUM_MAX
                                                         : pba_pkg::SUM_W'(acc);

    sh = pba_pkg::SH_W'(shift_q)
       + ((depth_q > pba_pkg::DEPTH_BASE) ? pba_pkg::SH_W'(depth_q - pba_pkg::DEPTH_BASE)
                                          : pba_pkg::SH_W'(0));
    sq = pba_pkg::SQ_W'(block_size_q) * pba_pkg::SQ_W'(block_size_q);

    sum_d   = sum_q;
    mean_d  = mean_q;
    count_d = count_q;
    if (cmd_i.adv) begin
      sum_d = sum_sat;
      if (cmd_i.emit) begin
        sum_d   = '0;
        mean_d  = sum_sat >> sh;
        count_d = (sq > pba_pkg::SQ_W'(pba_pkg::COUNT_MAX)) ? pba_pkg::COUNT_MAX
                                                           : pba_pkg::COUNT_W'(sq);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= pba_pkg::BLOCK_SIZE_RST;
      shift_q      <= pba_pkg::SHIFT_RST;
      depth_q      <= pba_pkg::DEPTH_BASE;
      col_q        <= '0;
      row_q        <= '0;
      sum_q        <= '0;
      s1_last_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          pba_pkg::CFG_BLOCK_SIZE:   block_size_q <= cfg_data_i;
          pba_pkg::CFG_SHIFT_AMOUNT: shift_q      <= pba_pkg::SHIFT_W'(cfg_data_i);
          pba_pkg::CFG_BIT_DEPTH:    depth_q      <= pba_pkg::DEPTH_W'(cfg_data_i);
          default: begin
          end
        endcase
      end
      col_q <= col_d;
      row_q <= row_d;
      sum_q <= sum_d;
      if (cmd_i.take) begin
        s1_last_q <= s1_last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      s1_sample_q <= sample_i;
      s1_w_q      <= s1_w_d;
    end
    mean_q  <= mean_d;
    count_q <= count_d;
  end

  assign stat_o.last    = s1_last_q;
  assign block_mean_o   = mean_q;
  assign sample_count_o = count_q;

endmodule

/* hdl/padded_block_average_core.sv */
// Top level of the padded block average core.
// Samples of one block enter in raster order on the input channel (valid and
// stall), each carrying the block's valid width and height. The core forms a
// weighted sum in which the last column and last row stand in for the missing
// edge samples, so a partial block counts as a full block_size square.
// A result transfer carries the shifted sum and block_size squared; it is
// produced once per block, on its last sample, and none otherwise.
// Throughput is one sample per cycle unless the input stalls. A sample is
// weighted in the cycle of its transfer and registered, then accumulated as
// that register advances, where one multiplier and the accumulator adder set
// the pace. The result enters the output register and holds there until taken.
// While the receiver stalls with a result waiting, samples keep flowing until
// the next block's last sample reaches the accumulator; the input stalls there.
// Configuration writes through the register port are always ready and must
// happen only while the core is idle. Reset restores block_size 8, shift 6,
// bit depth 8 and clears the accumulator, positions and output valid.
module padded_block_average_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pba_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  logic [pba_pkg::SIZE_W-1:0]         valid_width_i,
  input  logic [pba_pkg::SIZE_W-1:0]         valid_height_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pba_pkg::SUM_W-1:0]          block_mean_o,
  output logic [pba_pkg::COUNT_W-1:0]        sample_count_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pba_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pba_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  pba_pkg::pba_cmd_t  cmd;
  pba_pkg::pba_stat_t stat;

  assign cfg_ready_o = 1'b1;

  pba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  pba_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (sample_i),
    .valid_width_i  (valid_width_i),
    .valid_height_i (valid_height_i),
    .stat_o         (stat),
    .block_mean_o   (block_mean_o),
    .sample_count_o (sample_count_o)
  );

`ifndef SYNTH
  a_no_emit_over_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd.emit)
    else $error("Result overwritten while the receiver stalls.");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.emit))
    else $error("Result appeared without a completed block.");

  a_stall_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (cmd.busy && stat.last && out_valid_o))
    else $error("Input stalled without a held result.");
`endif

endmodule
